### sv/vector_slew_limiter_3d_core_defines.svh
// Assertion macros for the vector slew limiter checker.
`ifndef VECTOR_SLEW_LIMITER_3D_CORE_DEFINES_SVH
`define VECTOR_SLEW_LIMITER_3D_CORE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define VSL_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vsl assertion failed");

// Next-cycle implication, disabled in reset.
`define VSL_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vsl assertion failed");

// Next-cycle implication, also checked across reset.
`define VSL_ASSERT_RESET(label, ante, cons) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error("vsl reset assertion failed");

`endif

### sv/vsl_pkg.sv
// Shared types and constants of the vector slew limiter.
`timescale 1ns / 1ps
package vsl_pkg;

   localparam int COORD_W = 32;
   localparam int CFG_W   = 31;
   localparam int VEC_W   = 35;
   localparam int MAG_W   = 34;
   localparam int WIDE_W  = 68;

   localparam logic [1:0] KIND_TICK  = 2'd0;
   localparam logic [1:0] KIND_GOAL  = 2'd1;
   localparam logic [1:0] KIND_RESET = 2'd2;

   localparam logic [1:0] CSR_MAX_SPEED   = 2'd0;
   localparam logic [1:0] CSR_MAX_ACCEL   = 2'd1;
   localparam logic [1:0] CSR_TICK_PERIOD = 2'd2;

   localparam logic [CFG_W-1:0] SPEED_FLOOR     = 31'd7;
   localparam logic [CFG_W-1:0] ACCEL_FLOOR     = 31'd7;
   localparam logic [CFG_W-1:0] DT_ONE          = 31'h4000_0000;
   localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 31'd65536;
   localparam logic [CFG_W-1:0] MAX_ACCEL_RST   = 31'd65536;
   localparam logic [CFG_W-1:0] TICK_PERIOD_RST = 31'd1073742;

   typedef enum logic [1:0] {
      MDU_MUL,
      MDU_DIV,
      MDU_SQRT
   } mdu_op_type;

   typedef enum logic [4:0] {
      DP_NOP,
      DP_LOAD_GOAL,
      DP_LOAD_RESET,
      DP_DIFF,
      DP_MUL_SQ,
      DP_ACC_ADD,
      DP_SQRT_ACC,
      DP_SET_DEN,
      DP_MUL_BRAKE,
      DP_SQRT_BRAKE,
      DP_SET_SPD,
      DP_WANT_ZERO,
      DP_MUL_SCALE,
      DP_DIV_SCALE,
      DP_SET_WANT,
      DP_SET_SCALED,
      DP_MUL_DV,
      DP_SET_DVMAX,
      DP_SET_VMAX,
      DP_MUL_LIMSQ,
      DP_ADD_VEL,
      DP_SAT_VEL,
      DP_MUL_STEP,
      DP_SET_POS,
      DP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] idx;
   } dp_cmd_type;

   typedef struct packed {
      logic busy;
      logic acc_zero;
      logic longer;
      logic out_full;
   } dp_status_type;

endpackage

### sv/vsl_mdu.sv
// Serial multiply, divide and square root unit, one bit per cycle.
`timescale 1ns / 1ps
module vsl_mdu import vsl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  mdu_op_type        op,
   input  logic [WIDE_W-1:0] a,
   input  logic [MAG_W-1:0]  b,
   output logic              busy,
   output logic [WIDE_W-1:0] result
);

   localparam int REM_W = MAG_W + 4;
   localparam int CNT_W = 7;

   logic              busy_ff, busy_in;
   mdu_op_type        op_ff, op_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WIDE_W-1:0] x_ff, x_in;
   logic [MAG_W-1:0]  y_ff, y_in;
   logic [WIDE_W-1:0] r_ff, r_in;
   logic [REM_W-1:0]  rem_ff, rem_in;

   logic [MAG_W:0]    div_t;
   logic              div_ge;
   logic [REM_W-1:0]  sq_t;
   logic [REM_W-1:0]  sq_trial;
   logic              sq_ge;

   always_comb begin
      div_t    = {rem_ff[MAG_W-1:0], x_ff[WIDE_W-1]};
      div_ge   = div_t >= {1'b0, y_ff};
      sq_t     = {rem_ff[REM_W-3:0], x_ff[WIDE_W-1 -: 2]};
      sq_trial = {{(REM_W-MAG_W-2){1'b0}}, r_ff[MAG_W-1:0], 2'b01};
      sq_ge    = sq_t >= sq_trial;

      busy_in = busy_ff;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      r_in    = r_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         op_in   = op;
         cnt_in  = (op == MDU_DIV) ? CNT_W'(WIDE_W) : CNT_W'(MAG_W);
         x_in    = a;
         y_in    = b;
         r_in    = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         case (op_ff)
            MDU_MUL: begin
               r_in = y_ff[0] ? r_ff + x_ff : r_ff;
               x_in = x_ff << 1;
               y_in = y_ff >> 1;
            end
            MDU_DIV: begin
               rem_in = REM_W'(div_ge ? div_t - {1'b0, y_ff} : div_t);
               x_in   = {x_ff[WIDE_W-2:0], div_ge};
            end
            MDU_SQRT: begin
               rem_in = sq_ge ? sq_t - sq_trial : sq_t;
               r_in   = {r_ff[WIDE_W-2:0], sq_ge};
               x_in   = x_ff << 2;
            end
            default: begin
               busy_in = 1'b0;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      cnt_ff <= cnt_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      r_ff   <= r_in;
      rem_ff <= rem_in;
   end

   assign busy   = busy_ff;
   assign result = (op_ff == MDU_DIV) ? x_ff : r_ff;

endmodule

### sv/vsl_datapath.sv
// Datapath: state vectors, configuration registers, serial unit and result register.
`timescale 1ns / 1ps
module vsl_datapath import vsl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  dp_cmd_type                cmd,
   output dp_status_type             status,
   input  logic                      req_fire,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [CFG_W-1:0]          csr_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_pos_x,
   output logic signed [COORD_W-1:0] rsp_pos_y,
   output logic signed [COORD_W-1:0] rsp_pos_z,
   output logic signed [COORD_W-1:0] rsp_vel_x,
   output logic signed [COORD_W-1:0] rsp_vel_y,
   output logic signed [COORD_W-1:0] rsp_vel_z
);

   logic signed [COORD_W-1:0] coord_ff [3];
   logic signed [COORD_W-1:0] goal_ff  [3];
   logic signed [COORD_W-1:0] pos_ff   [3];
   logic signed [COORD_W-1:0] vel_ff   [3];
   logic signed [VEC_W-1:0]   vec_ff   [3];
   logic signed [COORD_W-1:0] out_pos_ff [3];
   logic signed [COORD_W-1:0] out_vel_ff [3];
   logic                      rsp_valid_ff;
   logic [WIDE_W-1:0]         acc_ff;
   logic [CFG_W-1:0]          num_ff;
   logic [MAG_W-1:0]          den_ff;
   logic                      neg_ff;
   logic [CFG_W-1:0]          max_speed_ff, max_accel_ff, tick_period_ff;

   logic [CFG_W-1:0]          speed_eff, accel_eff, dt_eff;
   logic signed [VEC_W-1:0]   vsel;
   logic [MAG_W-1:0]          vmag;
   logic signed [COORD_W-1:0] velsel;
   logic [COORD_W-1:0]        velmag;
   logic signed [VEC_W-1:0]   q_ext;
   logic [WIDE_W-1:0]         step_sum;
   logic [32:0]               step_m;
   logic signed [VEC_W-1:0]   pos_ext;

   logic                      mdu_start, mdu_busy;
   mdu_op_type                mdu_op;
   logic [WIDE_W-1:0]         mdu_a, mdu_res;
   logic [MAG_W-1:0]          mdu_b;

   function automatic logic signed [COORD_W-1:0] sat32(input logic signed [VEC_W-1:0] v);
      if (v > 35'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -35'sd2147483648) begin
         return 32'sh8000_0000;
      end
      return v[COORD_W-1:0];
   endfunction

   assign speed_eff = (max_speed_ff < SPEED_FLOOR) ? SPEED_FLOOR : max_speed_ff;
   assign accel_eff = (max_accel_ff < ACCEL_FLOOR) ? ACCEL_FLOOR : max_accel_ff;
   assign dt_eff    = (tick_period_ff == '0) ? CFG_W'(1) :
                      (tick_period_ff > DT_ONE) ? DT_ONE : tick_period_ff;

   always_comb begin
      vsel     = vec_ff[cmd.idx];
      vmag     = vsel[VEC_W-1] ? MAG_W'(-vsel) : MAG_W'(vsel);
      velsel   = vel_ff[cmd.idx];
      velmag   = velsel[COORD_W-1] ? COORD_W'(-velsel) : COORD_W'(velsel);
      q_ext    = $signed({3'b000, mdu_res[COORD_W-1:0]});
      step_sum = mdu_res + (WIDE_W'(1) << 29);
      step_m   = step_sum[62:30];
      pos_ext  = VEC_W'(pos_ff[cmd.idx]);
   end

   always_comb begin
      mdu_start = 1'b0;
      mdu_op    = MDU_MUL;
      mdu_a     = '0;
      mdu_b     = '0;
      case (cmd.op)
         DP_MUL_SQ: begin
            mdu_start = 1'b1;
            mdu_a     = WIDE_W'(vmag);
            mdu_b     = vmag;
         end
         DP_SQRT_ACC: begin
            mdu_start = 1'b1;
            mdu_op    = MDU_SQRT;
            mdu_a     = acc_ff;
         end
         DP_MUL_BRAKE: begin
            mdu_start = 1'b1;
            mdu_a     = WIDE_W'(accel_eff);
            mdu_b     = den_ff;
         end
         DP_SQRT_BRAKE: begin
            mdu_start = 1'b1;
            mdu_op    = MDU_SQRT;
            mdu_a     = {mdu_res[WIDE_W-2:0], 1'b0};
         end
         DP_MUL_SCALE: begin
            mdu_start = 1'b1;
            mdu_a     = WIDE_W'(vmag);
            mdu_b     = MAG_W'(num_ff);
         end
         DP_DIV_SCALE: begin
            mdu_start = 1'b1;
            mdu_op    = MDU_DIV;
            mdu_a     = mdu_res;
            mdu_b     = den_ff;
         end
         DP_MUL_DV: begin
            mdu_start = 1'b1;
            mdu_a     = WIDE_W'(accel_eff);
            mdu_b     = MAG_W'(dt_eff);
         end
         DP_MUL_LIMSQ: begin
            mdu_start = 1'b1;
            mdu_a     = WIDE_W'(num_ff);
            mdu_b     = MAG_W'(num_ff);
         end
         DP_MUL_STEP: begin
            mdu_start = 1'b1;
            mdu_a     = WIDE_W'(velmag);
            mdu_b     = MAG_W'(dt_eff);
         end
         default: begin
            mdu_start = 1'b0;
         end
      endcase
   end

   vsl_mdu u_mdu (
      .clock  (clock),
      .reset  (reset),
      .start  (mdu_start),
      .op     (mdu_op),
      .a      (mdu_a),
      .b      (mdu_b),
      .busy   (mdu_busy),
      .result (mdu_res)
   );

   // Architectural state, configuration and result handshake.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_speed_ff   <= MAX_SPEED_RST;
         max_accel_ff   <= MAX_ACCEL_RST;
         tick_period_ff <= TICK_PERIOD_RST;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            goal_ff[i] <= '0;
            pos_ff[i]  <= '0;
            vel_ff[i]  <= '0;
         end
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_SPEED:   max_speed_ff   <= csr_data;
               CSR_MAX_ACCEL:   max_accel_ff   <= csr_data;
               CSR_TICK_PERIOD: tick_period_ff <= csr_data;
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (cmd.op)
            DP_LOAD_GOAL: begin
               for (int i = 0; i < 3; i++) begin
                  goal_ff[i] <= coord_ff[i];
               end
            end
            DP_LOAD_RESET: begin
               for (int i = 0; i < 3; i++) begin
                  goal_ff[i] <= coord_ff[i];
                  pos_ff[i]  <= coord_ff[i];
                  vel_ff[i]  <= '0;
               end
            end
            DP_SAT_VEL: begin
               for (int i = 0; i < 3; i++) begin
                  vel_ff[i] <= sat32(vec_ff[i]);
               end
            end
            DP_SET_POS: begin
               pos_ff[cmd.idx] <= sat32(neg_ff ? pos_ext - $signed({2'b00, step_m})
                                               : pos_ext + $signed({2'b00, step_m}));
            end
            DP_OUT: begin
               rsp_valid_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Working registers of the tick computation.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
      end
      case (cmd.op)
         DP_DIFF: begin
            for (int i = 0; i < 3; i++) begin
               vec_ff[i] <= VEC_W'(goal_ff[i]) - VEC_W'(pos_ff[i]);
            end
         end
         DP_MUL_SQ: begin
            if (cmd.idx == 2'd0) begin
               acc_ff <= '0;
            end
         end
         DP_ACC_ADD:    acc_ff <= acc_ff + mdu_res;
         DP_SET_DEN:    den_ff <= mdu_res[MAG_W-1:0];
         DP_SET_SPD: begin
            num_ff <= (mdu_res[MAG_W-1:0] < MAG_W'(speed_eff)) ? CFG_W'(mdu_res) : speed_eff;
         end
         DP_WANT_ZERO: begin
            for (int i = 0; i < 3; i++) begin
               vec_ff[i] <= -VEC_W'(vel_ff[i]);
            end
         end
         DP_MUL_SCALE:  neg_ff <= vsel[VEC_W-1];
         DP_SET_WANT: begin
            vec_ff[cmd.idx] <= (neg_ff ? -q_ext : q_ext) - VEC_W'(vel_ff[cmd.idx]);
         end
         DP_SET_SCALED: vec_ff[cmd.idx] <= neg_ff ? -q_ext : q_ext;
         DP_SET_DVMAX:  num_ff <= mdu_res[60:30];
         DP_SET_VMAX:   num_ff <= speed_eff;
         DP_ADD_VEL: begin
            for (int i = 0; i < 3; i++) begin
               vec_ff[i] <= VEC_W'(vel_ff[i]) + vec_ff[i];
            end
         end
         DP_MUL_STEP:   neg_ff <= velsel[COORD_W-1];
         DP_OUT: begin
            for (int i = 0; i < 3; i++) begin
               out_pos_ff[i] <= pos_ff[i];
               out_vel_ff[i] <= vel_ff[i];
            end
         end
         default: ;
      endcase
   end

   assign status.busy     = mdu_busy | mdu_start;
   assign status.acc_zero = (acc_ff == '0);
   assign status.longer   = (acc_ff > mdu_res);
   assign status.out_full = rsp_valid_ff;

   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pos_x = out_pos_ff[0];
   assign rsp_pos_y = out_pos_ff[1];
   assign rsp_pos_z = out_pos_ff[2];
   assign rsp_vel_x = out_vel_ff[0];
   assign rsp_vel_y = out_vel_ff[1];
   assign rsp_vel_z = out_vel_ff[2];

endmodule

### sv/vsl_ctrl.sv
// Controller: sequences the tick computation through the datapath.
`timescale 1ns / 1ps
module vsl_ctrl import vsl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  logic [1:0]    req_kind,
   output dp_cmd_type    cmd,
   input  dp_status_type status
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_SQ,
      S_SQ_W,
      S_SQ_END,
      S_ZCHK,
      S_DIST_W,
      S_BRK,
      S_BRK_W,
      S_BSQ_W,
      S_SCL,
      S_SCL_W,
      S_DIV_W,
      S_SCL_END,
      S_DV,
      S_DV_W,
      S_LIM_W,
      S_LEN_W,
      S_VM,
      S_STEP,
      S_STEP_W,
      S_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_DIST,
      PH_DELTA,
      PH_SPEED
   } phase_type;

   state_type  state_ff;
   phase_type  phase_ff;
   logic [1:0] idx_ff;
   dp_cmd_type cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_DIST;
         idx_ff     <= '0;
         cmd_ff.op  <= DP_NOP;
         cmd_ff.idx <= '0;
      end else begin
         cmd_ff.op  <= DP_NOP;
         cmd_ff.idx <= idx_ff;
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  case (req_kind)
                     KIND_TICK: begin
                        cmd_ff.op <= DP_DIFF;
                        phase_ff  <= PH_DIST;
                        idx_ff    <= '0;
                        state_ff  <= S_SQ;
                     end
                     KIND_GOAL:  cmd_ff.op <= DP_LOAD_GOAL;
                     KIND_RESET: cmd_ff.op <= DP_LOAD_RESET;
                     default: ;
                  endcase
               end
            end
            S_SQ: begin
               cmd_ff.op <= DP_MUL_SQ;
               state_ff  <= S_SQ_W;
            end
            S_SQ_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_ACC_ADD;
                  if (idx_ff == 2'd2) begin
                     state_ff <= S_SQ_END;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SQ;
                  end
               end
            end
            S_SQ_END: begin
               if (phase_ff == PH_DIST) begin
                  state_ff <= S_ZCHK;
               end else begin
                  cmd_ff.op <= DP_MUL_LIMSQ;
                  state_ff  <= S_LIM_W;
               end
            end
            S_ZCHK: begin
               if (status.acc_zero) begin
                  cmd_ff.op <= DP_WANT_ZERO;
                  state_ff  <= S_DV;
               end else begin
                  cmd_ff.op <= DP_SQRT_ACC;
                  state_ff  <= S_DIST_W;
               end
            end
            S_DIST_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_SET_DEN;
                  state_ff  <= S_BRK;
               end
            end
            S_BRK: begin
               cmd_ff.op <= DP_MUL_BRAKE;
               state_ff  <= S_BRK_W;
            end
            S_BRK_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_SQRT_BRAKE;
                  state_ff  <= S_BSQ_W;
               end
            end
            S_BSQ_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_SET_SPD;
                  idx_ff    <= '0;
                  state_ff  <= S_SCL;
               end
            end
            S_SCL: begin
               cmd_ff.op <= DP_MUL_SCALE;
               state_ff  <= S_SCL_W;
            end
            S_SCL_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_DIV_SCALE;
                  state_ff  <= S_DIV_W;
               end
            end
            S_DIV_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= (phase_ff == PH_DIST) ? DP_SET_WANT : DP_SET_SCALED;
                  if (idx_ff == 2'd2) begin
                     state_ff <= S_SCL_END;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_SCL;
                  end
               end
            end
            S_SCL_END: begin
               case (phase_ff)
                  PH_DIST: state_ff <= S_DV;
                  PH_DELTA: begin
                     cmd_ff.op <= DP_ADD_VEL;
                     state_ff  <= S_VM;
                  end
                  default: begin
                     cmd_ff.op <= DP_SAT_VEL;
                     idx_ff    <= '0;
                     state_ff  <= S_STEP;
                  end
               endcase
            end
            S_DV: begin
               cmd_ff.op <= DP_MUL_DV;
               state_ff  <= S_DV_W;
            end
            S_DV_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_SET_DVMAX;
                  phase_ff  <= PH_DELTA;
                  idx_ff    <= '0;
                  state_ff  <= S_SQ;
               end
            end
            S_LIM_W: begin
               if (!status.busy) begin
                  if (status.longer) begin
                     cmd_ff.op <= DP_SQRT_ACC;
                     state_ff  <= S_LEN_W;
                  end else begin
                     state_ff <= S_SCL_END;
                  end
               end
            end
            S_LEN_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_SET_DEN;
                  idx_ff    <= '0;
                  state_ff  <= S_SCL;
               end
            end
            S_VM: begin
               cmd_ff.op <= DP_SET_VMAX;
               phase_ff  <= PH_SPEED;
               idx_ff    <= '0;
               state_ff  <= S_SQ;
            end
            S_STEP: begin
               cmd_ff.op <= DP_MUL_STEP;
               state_ff  <= S_STEP_W;
            end
            S_STEP_W: begin
               if (!status.busy) begin
                  cmd_ff.op <= DP_SET_POS;
                  if (idx_ff == 2'd2) begin
                     state_ff <= S_OUT;
                  end else begin
                     idx_ff   <= idx_ff + 1'b1;
                     state_ff <= S_STEP;
                  end
               end
            end
            S_OUT: begin
               if (!status.out_full) begin
                  cmd_ff.op <= DP_OUT;
                  state_ff  <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign cmd       = cmd_ff;

endmodule

### sv/vector_slew_limiter_3d_core.sv
// Top level of the 3D vector slew limiter: controller plus datapath.
//
// Usage:
//   req_* carries one transaction: kind 0 is a tick, kind 1 sets the goal to
//   req_coord_*, kind 2 moves position and goal to req_coord_* and zeroes the
//   velocity, kind 3 is ignored. Only a tick produces a rsp_* transaction with
//   the new position and velocity.
//   csr_* writes max_speed (index 0), max_accel (1) and tick_period (2); it is
//   always ready and should only be used while the block is idle.
// Timing:
//   Set-goal and reset transactions leave the controller idle and ready. Every
//   multiply, divide and square root of a tick runs through one serial unit at
//   one bit per cycle, and the length of a tick depends on whether the step and
//   speed limits engage.
//   The next transaction is accepted when the tick sequence is done.
// Reset: synchronous; position, velocity and goal clear and the registers
//   return to their defaults.
// Stall: a result waits in the output register while rsp_ready is low; a
//   further tick completes its computation and then holds until it drains.
`timescale 1ns / 1ps
module vector_slew_limiter_3d_core import vsl_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_kind,
   input  logic signed [COORD_W-1:0] req_coord_x,
   input  logic signed [COORD_W-1:0] req_coord_y,
   input  logic signed [COORD_W-1:0] req_coord_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [COORD_W-1:0] rsp_pos_x,
   output logic signed [COORD_W-1:0] rsp_pos_y,
   output logic signed [COORD_W-1:0] rsp_pos_z,
   output logic signed [COORD_W-1:0] rsp_vel_x,
   output logic signed [COORD_W-1:0] rsp_vel_y,
   output logic signed [COORD_W-1:0] rsp_vel_z,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [1:0]                csr_index,
   input  logic [CFG_W-1:0]          csr_data
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_fire;

   assign req_fire = req_valid & req_ready;

   vsl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_kind  (req_kind),
      .cmd       (cmd),
      .status    (status)
   );

   vsl_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_fire    (req_fire),
      .req_coord_x (req_coord_x),
      .req_coord_y (req_coord_y),
      .req_coord_z (req_coord_z),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_pos_z   (rsp_pos_z),
      .rsp_vel_x   (rsp_vel_x),
      .rsp_vel_y   (rsp_vel_y),
      .rsp_vel_z   (rsp_vel_z)
   );

endmodule

### sv/vsl_checker.sv
// Port-level assertion checker for the vector slew limiter, with its bind.
`timescale 1ns / 1ps
`include "vector_slew_limiter_3d_core_defines.svh"
module vsl_checker import vsl_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [1:0]                req_kind,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic signed [COORD_W-1:0] rsp_pos_x,
   input logic signed [COORD_W-1:0] rsp_vel_z
);

   // a stalled result transaction holds
   `VSL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_pos_x, rsp_vel_z}))

   // a tick keeps the block busy past the accepting cycle
   `VSL_ASSERT_NEXT(a_tick_busy, req_valid && req_ready && (req_kind == KIND_TICK), !req_ready)

   // a result appears only as a tick sequence finishes
   `VSL_ASSERT_NOW(a_rsp_after_tick, $rose(rsp_valid), !$past(req_ready, 2))

   `VSL_ASSERT_RESET(a_reset_clear, reset, !rsp_valid && req_ready)

endmodule

bind vector_slew_limiter_3d_core vsl_checker u_vsl_checker (.*);
